// ===== rtl/core/unicycle_ekf_predict_top_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef UNICYCLE_EKF_PREDICT_TOP_MACROS_SVH
`define UNICYCLE_EKF_PREDICT_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define EKFP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ekfp assertion failed");

// next-cycle implication, disabled while in reset
`define EKFP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ekfp assertion failed");

`endif

// ===== rtl/core/ekfp_pkg.sv =====
// shared types, constants and helper functions of the unicycle ekf predict block
package ekfp_pkg;

	localparam int TRIG_W       = 32;
	localparam int COV_W        = 32;
	localparam int MUL_W        = 34;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 272;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int CORDIC_STEPS = 24;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE     = 32'sd1073741824;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [TRIG_W-1:0] TURN_PER_RAD = 32'sd683565276;

	localparam logic [15:0] STEP_TIME_RST     = 16'd6554;
	localparam logic [31:0] INIT_X_RST        = 32'd0;
	localparam logic [31:0] INIT_Y_RST        = 32'd0;
	localparam logic [15:0] INIT_HEADING_RST  = 16'd10430;
	localparam logic [30:0] INIT_VARIANCE_RST = 31'd1677722;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_TIME,
		CFG_INIT_X,
		CFG_INIT_Y,
		CFG_INIT_HEADING,
		CFG_INIT_VARIANCE
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	// arctangent of 2^-i in 2^-32 turns
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (x < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/ekfp_cordic.sv =====
// iterative rotation cordic giving cos and sin of a binary angle, one step a cycle
module ekfp_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic                  done,
	output ekfp_pkg::trig_t       trig
);
	import ekfp_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] z_q;
	logic [4:0]         step_q;
	logic               run_q, done_q, flip_q;

	logic [31:0]        t;
	logic signed [32:0] z0;
	logic signed [33:0] dx, dy, fx, fy;
	logic signed [32:0] at;

	assign t  = {angle, {(32 - ANGLE_BITS){1'b0}}};
	assign z0 = 33'(signed'(t));
	assign dx = cx_q >>> step_q;
	assign dy = cy_q >>> step_q;
	assign at = 33'(signed'({1'b0, atan_turn(step_q)}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 5'd1;
			if (step_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= 34'(CORDIC_GAIN);
			cy_q <= '0;
			// fold the angle into the right half plane
			if (z0 > 33'sd1073741824) begin
				z_q    <= z0 - 33'sd2147483648;
				flip_q <= 1'b1;
			end else if (z0 < -33'sd1073741824) begin
				z_q    <= z0 + 33'sd2147483648;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end else if (run_q) begin
			if (z_q >= 0) begin
				cx_q <= cx_q - dy;
				cy_q <= cy_q + dx;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + dy;
				cy_q <= cy_q - dx;
				z_q  <= z_q + at;
			end
		end
	end

	assign fx = flip_q ? -cx_q : cx_q;
	assign fy = flip_q ? -cy_q : cy_q;

	always_comb begin
		if (fx > 34'(TRIG_ONE))
			trig.cos_v = TRIG_ONE;
		else if (fx < -34'(TRIG_ONE))
			trig.cos_v = -TRIG_ONE;
		else
			trig.cos_v = fx[31:0];
		if (fy > 34'(TRIG_ONE))
			trig.sin_v = TRIG_ONE;
		else if (fy < -34'(TRIG_ONE))
			trig.sin_v = -TRIG_ONE;
		else
			trig.sin_v = fy[31:0];
	end

	assign done = done_q;

endmodule

// ===== rtl/core/ekfp_mul.sv =====
// shared signed multiplier with registered product
module ekfp_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ekfp_pkg::MUL_W-1:0]   op_a,
	input  logic signed [ekfp_pkg::MUL_W-1:0]   op_b,
	output logic signed [ekfp_pkg::PROD_W-1:0]  prod
);
	import ekfp_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/core/unicycle_ekf_predict_top.sv =====
// top level of the unicycle ekf predict block: sequencer, state and output register
// Prediction step of an extended Kalman filter for a unicycle robot.
// Input channel s_axis: tuser is the mode (0 predict one tick, 1 restart),
// tdata holds speed (Q8.8) and turn rate (Q4.12). One item gives one result.
// Output channel m_axis: tdata holds the new pose and the six covariance terms.
// Configuration: cfg_wr_en / cfg_index / cfg_data write step time, initial pose
// and initial variance; write them only while the block is idle.
// A predict item runs from accept to result through the 24-step
// CORDIC on the old heading, then ten multiplies on the one shared
// multiplier (pose steps and the F P F^T terms). Three multiplies before
// them (v dt, w dt, heading step) run while the CORDIC turns.
// A restart item goes through ST_FIN; its result shows once the output is free.
// s_axis_tready is high only while the sequencer is idle; one finished result
// waits in the output register, so the next item is taken while it is held.
// If the receiver stalls with a result still held, the next result waits in
// the sequencer until the output register frees up.
// Reset (arst_n low) loads the register reset values and the pose and
// covariance that a restart from them gives; no result is pending after reset.
module unicycle_ekf_predict_top #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [ekfp_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // speed, turn_rate
	input  logic                                 s_axis_tuser,  // mode
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// pos_x, pos_y, heading, var_xx, cov_xy, cov_xh, var_yy, cov_yh, var_hh
	output logic [ekfp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [ekfp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ekfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ekfp_pkg::*;

	localparam int ANG_SH = 60 - ANGLE_BITS;
	localparam logic signed [PROD_W-1:0] ANG_HALF = 68'sd1 <<< (ANG_SH - 1);
	localparam logic [39:0] IH_RST_EXT = {INIT_HEADING_RST, 24'b0};

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;
	typedef enum logic [3:0] {
		OP_VDT, OP_WDT, OP_ANG, OP_PX, OP_PY,
		OP_M00, OP_M01, OP_M02, OP_M11, OP_M12,
		OP_XX, OP_XY, OP_YY
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic   phase_q;
	logic   m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	logic [15:0] step_time_q, init_heading_q;
	logic [31:0] init_x_q, init_y_q;
	logic [30:0] init_variance_q;

	logic signed [31:0] pose_x_q, pose_y_q;
	logic [ANGLE_BITS-1:0] heading_q;
	logic signed [31:0] xx_q, xy_q, xh_q, yy_q, yh_q, hh_q;
	logic signed [15:0] speed_q, turn_q;
	logic signed [32:0] vdt_q, wdt_q;
	logic signed [33:0] a_q, b_q;

	logic s_acc, cordic_done, mul_en;
	trig_t trig;
	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] prod, rnd24, rnd38, rnd30, rnd_ang;
	logic signed [43:0] r24;
	logic signed [29:0] r38;
	logic signed [33:0] r30;
	logic signed [31:0] base;
	logic signed [31:0] mac_res;
	logic [39:0] ih_ext;
	logic [ANGLE_BITS+15:0] hd_ext;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign ih_ext        = {init_heading_q, 24'b0};
	assign hd_ext        = {heading_q, 16'b0};

	ekfp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_acc && !s_axis_tuser),
		.angle  (heading_q),
		.done   (cordic_done),
		.trig   (trig)
	);

	ekfp_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// operand select and accumulate base for each step
	always_comb begin
		op_a = '0;
		op_b = '0;
		base = '0;
		case (op_q)
			OP_VDT: begin op_a = 34'(speed_q); op_b = 34'(signed'({1'b0, step_time_q})); end
			OP_WDT: begin op_a = 34'(turn_q);  op_b = 34'(signed'({1'b0, step_time_q})); end
			OP_ANG: begin op_a = 34'(wdt_q);   op_b = 34'(TURN_PER_RAD); end
			OP_PX:  begin op_a = 34'(vdt_q);   op_b = 34'(trig.cos_v); end
			OP_PY:  begin op_a = 34'(vdt_q);   op_b = 34'(trig.sin_v); end
			OP_M00: begin op_a = a_q; op_b = 34'(xh_q); base = xx_q; end
			OP_M01: begin op_a = a_q; op_b = 34'(yh_q); base = xy_q; end
			OP_M02: begin op_a = a_q; op_b = 34'(hh_q); base = xh_q; end
			OP_M11: begin op_a = b_q; op_b = 34'(yh_q); base = yy_q; end
			OP_M12: begin op_a = b_q; op_b = 34'(hh_q); base = yh_q; end
			OP_XX:  begin op_a = a_q; op_b = 34'(xh_q); base = xx_q; end
			OP_XY:  begin op_a = b_q; op_b = 34'(xh_q); base = xy_q; end
			OP_YY:  begin op_a = b_q; op_b = 34'(yh_q); base = yy_q; end
			default: begin op_a = '0; op_b = '0; base = '0; end
		endcase
	end

	// round half up: add half an lsb, then drop bits (floor)
	assign rnd24   = prod + 68'sd8388608;
	assign rnd38   = prod + 68'sd137438953472;
	assign rnd30   = prod + 68'sd536870912;
	assign rnd_ang = prod + ANG_HALF;
	assign r24     = rnd24[67:24];
	assign r38     = rnd38[67:38];
	assign r30     = rnd30[63:30];
	assign mac_res = sat32(48'(base) + 48'(r24));

	assign mul_en = (state_q == ST_RUN) && !phase_q && ((op_q < OP_PX) || cordic_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			op_q            <= OP_VDT;
			phase_q         <= 1'b0;
			m_valid_q       <= 1'b0;
			step_time_q     <= STEP_TIME_RST;
			init_x_q        <= INIT_X_RST;
			init_y_q        <= INIT_Y_RST;
			init_heading_q  <= INIT_HEADING_RST;
			init_variance_q <= INIT_VARIANCE_RST;
			pose_x_q        <= signed'(INIT_X_RST);
			pose_y_q        <= signed'(INIT_Y_RST);
			heading_q       <= IH_RST_EXT[39 -: ANGLE_BITS];
			xx_q            <= 32'(signed'({1'b0, INIT_VARIANCE_RST}));
			xy_q            <= '0;
			xh_q            <= '0;
			yy_q            <= 32'(signed'({1'b0, INIT_VARIANCE_RST}));
			yh_q            <= '0;
			hh_q            <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_STEP_TIME:     step_time_q     <= cfg_data[15:0];
					CFG_INIT_X:        init_x_q        <= cfg_data;
					CFG_INIT_Y:        init_y_q        <= cfg_data;
					CFG_INIT_HEADING:  init_heading_q  <= cfg_data[15:0];
					CFG_INIT_VARIANCE: init_variance_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			// in ST_FIN the output valid is handled by the state machine below
			if (m_valid_q && m_axis_tready && (state_q != ST_FIN))
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_axis_tuser) begin
							pose_x_q  <= signed'(init_x_q);
							pose_y_q  <= signed'(init_y_q);
							heading_q <= ih_ext[39 -: ANGLE_BITS];
							xx_q      <= 32'(signed'({1'b0, init_variance_q}));
							xy_q      <= '0;
							xh_q      <= '0;
							yy_q      <= 32'(signed'({1'b0, init_variance_q}));
							yh_q      <= '0;
							hh_q      <= '0;
							state_q   <= ST_FIN;
						end else begin
							op_q    <= OP_VDT;
							phase_q <= 1'b0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (!phase_q) begin
						if (mul_en)
							phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						case (op_q)
							OP_ANG: heading_q <= heading_q + rnd_ang[ANG_SH+ANGLE_BITS-1:ANG_SH];
							OP_PX:  pose_x_q  <= sat32(48'(pose_x_q) + 48'(r38));
							OP_PY:  pose_y_q  <= sat32(48'(pose_y_q) + 48'(r38));
							OP_M00, OP_XX: xx_q <= mac_res;
							OP_M01, OP_XY: xy_q <= mac_res;
							OP_M02: xh_q <= mac_res;
							OP_M11, OP_YY: yy_q <= mac_res;
							OP_M12: yh_q <= mac_res;
							default: ;
						endcase
						if (op_q == OP_YY)
							state_q <= ST_FIN;
						else
							op_q <= op_t'(op_q + 4'd1);
					end
				end
				ST_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			speed_q <= signed'(s_axis_tdata[15:0]);
			turn_q  <= signed'(s_axis_tdata[31:16]);
		end
		if ((state_q == ST_RUN) && phase_q) begin
			case (op_q)
				OP_VDT: vdt_q <= prod[32:0];
				OP_WDT: wdt_q <= prod[32:0];
				OP_PX:  b_q   <= r30;
				OP_PY:  a_q   <= -r30;
				default: ;
			endcase
		end
		if ((state_q == ST_FIN) && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {hh_q, yh_q, yy_q, xh_q, xy_q, xx_q,
				hd_ext[ANGLE_BITS+15 -: 16], pose_y_q, pose_x_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/core/ekfp_checker.sv =====
// port-level checker of the unicycle ekf predict block and its bind
`include "unicycle_ekf_predict_top_macros.svh"
module ekfp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [ekfp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	input logic                                 s_axis_tuser,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [ekfp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	input logic                                 cfg_wr_en,
	input logic [ekfp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [ekfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ekfp_pkg::*;

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// a stalled result holds
	`EKFP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a predict item keeps the block busy for the cordic and multiplies
	`EKFP_ASSERT_NEXT(a_busy_predict, clk, arst_n, s_acc && !s_axis_tuser, !s_axis_tready ##4 !s_axis_tready)

	// a restart with a free output first drops ready, then shows its result
	`EKFP_ASSERT_NEXT(a_restart_out, clk, arst_n, s_acc && s_axis_tuser && (!m_axis_tvalid || m_axis_tready), !s_axis_tready ##1 m_axis_tvalid)

	// a fresh result always comes with the input side free again
	`EKFP_ASSERT_IMPL(a_ready_with_result, clk, arst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind unicycle_ekf_predict_top ekfp_checker u_ekfp_checker (.*);

// ===== verif/tb_unicycle_ekf_predict_top.sv =====
// testbench: random and directed odometry ticks against a unicycle ekf predictor
`timescale 1ns / 100ps

module tb_unicycle_ekf_predict_top;
	import ekfp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED_HI = 3'd7;
	localparam longint GAIN     = 652032874;
	localparam longint UNIT_TRIG = 1073741824;
	localparam longint RAD_TURN = 683565276;
	localparam int     SETTLE   = 80;
	localparam int     WDOG_MAX = 5000;
	localparam int     HOLD_LEN = 400;

	typedef struct {
		bit          restart;
		bit [15:0]   speed;
		bit [15:0]   turn;
	} tick_t;

	typedef struct {
		bit [31:0] pos_x;
		bit [31:0] pos_y;
		bit [15:0] heading;
		bit [31:0] cov[6];
	} pose_cov_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tick_t     pending_ticks[$];
	pose_cov_t pose_cov_q[$];
	int        err_cnt = 0;
	int        idle_pct = 21;
	int        hold_seq = 0;
	int        hold_seen = 0;
	int        hold_cnt = 0;
	int        wdog = 0;
	bit        tx_pause = 0;

	// predictor registers and state
	bit [15:0] r_dt = STEP_TIME_RST;
	bit [31:0] r_ix = INIT_X_RST;
	bit [31:0] r_iy = INIT_Y_RST;
	bit [15:0] r_ih = INIT_HEADING_RST;
	bit [30:0] r_iv = INIT_VARIANCE_RST;
	longint    st_x, st_y;
	bit [15:0] st_head;
	longint    st_cov[6];

	longint atan_tab[24] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

	unicycle_ekf_predict_top DUT (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic longint rnd_shift(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint mac_q24(longint p, longint k, longint q);
		return clip32(p + rnd_shift(k * q, 24));
	endfunction

	function automatic void reload_pose();
		st_x = longint'($signed(r_ix));
		st_y = longint'($signed(r_iy));
		st_head = r_ih;
		st_cov = '{longint'(r_iv), 0, 0, longint'(r_iv), 0, 0};
	endfunction

	// cordic on the old heading, result Q2.30
	function automatic void heading_trig(bit [15:0] h, output longint c, output longint s);
		longint z, cx, cy, dx, dy;
		bit flip;
		z = longint'($signed({h, 16'h0000}));
		flip = 0;
		cx = GAIN;
		cy = 0;
		if (z > (longint'(1) <<< 30)) begin
			z -= longint'(1) <<< 31; flip = 1;
		end else if (z < -(longint'(1) <<< 30)) begin
			z += longint'(1) <<< 31; flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = cx >>> i;
			dy = cy >>> i;
			if (z >= 0) begin
				cx -= dy; cy += dx; z -= atan_tab[i];
			end else begin
				cx += dy; cy -= dx; z += atan_tab[i];
			end
		end
		if (flip) begin
			cx = -cx; cy = -cy;
		end
		c = (cx > UNIT_TRIG) ? UNIT_TRIG : (cx < -UNIT_TRIG) ? -UNIT_TRIG : cx;
		s = (cy > UNIT_TRIG) ? UNIT_TRIG : (cy < -UNIT_TRIG) ? -UNIT_TRIG : cy;
	endfunction

	function automatic pose_cov_t advance_pose_cov(tick_t t);
		pose_cov_t r;
		longint v, w, dt, vdt, c, s, a, b, dang;
		longint m00, m01, m02, m11, m12;
		if (t.restart) begin
			reload_pose();
		end else begin
			v = longint'($signed(t.speed));
			w = longint'($signed(t.turn));
			dt = longint'(r_dt);
			vdt = v * dt;
			heading_trig(st_head, c, s);
			st_x = clip32(st_x + rnd_shift(vdt * c, 38));
			st_y = clip32(st_y + rnd_shift(vdt * s, 38));
			dang = rnd_shift(w * dt * RAD_TURN, 44);
			st_head = st_head + dang[15:0];
			a = -rnd_shift(vdt * s, 30);
			b = rnd_shift(vdt * c, 30);
			m00 = mac_q24(st_cov[0], a, st_cov[2]);
			m01 = mac_q24(st_cov[1], a, st_cov[4]);
			m02 = mac_q24(st_cov[2], a, st_cov[5]);
			m11 = mac_q24(st_cov[3], b, st_cov[4]);
			m12 = mac_q24(st_cov[4], b, st_cov[5]);
			st_cov[0] = mac_q24(m00, a, m02);
			st_cov[1] = mac_q24(m01, b, m02);
			st_cov[2] = m02;
			st_cov[3] = mac_q24(m11, b, m12);
			st_cov[4] = m12;
		end
		r.pos_x = st_x[31:0];
		r.pos_y = st_y[31:0];
		r.heading = st_head;
		for (int k = 0; k < 6; k++) r.cov[k] = st_cov[k][31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pose_cov_q.push_back(advance_pose_cov('{s_axis_tuser,
					s_axis_tdata[15:0], s_axis_tdata[31:16]}));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ticks.size() > 0 && !tx_pause &&
						$urandom_range(99) >= idle_pct) begin
					tick_t t;
					t = pending_ticks.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= t.restart;
					s_axis_tdata <= {t.turn, t.speed};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with a single long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_cnt <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pose_cov_q.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata[31:0], 32'h0);
			end else begin
				pose_cov_t e;
				e = pose_cov_q.pop_front();
				if (m_axis_tdata[31:0] !== e.pos_x)
					report_mismatch("pos_x", m_axis_tdata[31:0], e.pos_x);
				if (m_axis_tdata[63:32] !== e.pos_y)
					report_mismatch("pos_y", m_axis_tdata[63:32], e.pos_y);
				if (m_axis_tdata[79:64] !== e.heading)
					report_mismatch("heading", 32'(m_axis_tdata[79:64]), 32'(e.heading));
				for (int k = 0; k < 6; k++)
					if (m_axis_tdata[80+32*k +: 32] !== e.cov[k])
						report_mismatch($sformatf("cov[%0d]", k),
							m_axis_tdata[80+32*k +: 32], e.cov[k]);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("tb_unicycle_ekf_predict_top failed");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_STEP_TIME:     r_dt = val[15:0];
			CFG_INIT_X:        r_ix = val;
			CFG_INIT_Y:        r_iy = val;
			CFG_INIT_HEADING:  r_ih = val[15:0];
			CFG_INIT_VARIANCE: r_iv = val[30:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_ticks.size() > 0 || s_axis_tvalid || pose_cov_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_tick(int rs, bit [15:0] sp, bit [15:0] tr);
		pending_ticks.push_back('{rs != 0, sp, tr});
	endtask

	function automatic bit [15:0] rand_rate();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5) return 16'($urandom);
		if (sel < 8) return 16'($signed($urandom_range(4096)) - 2048);
		return sel[0] ? 16'h7FFF : 16'h8000;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			add_tick(int'($urandom_range(99) < 5), rand_rate(), rand_rate());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reload_pose();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, extremes, restart, wrap, zero step
		add_tick(0, 16'h0100, 16'h1000);
		add_tick(0, 16'h7FFF, 16'h7FFF);
		add_tick(0, 16'h8000, 16'h8000);
		add_tick(0, 16'h0000, 16'h0000);
		add_tick(0, 16'hFFFF, 16'hFFFF);
		add_tick(1, 16'h0000, 16'h0000);
		for (int i = 0; i < 6; i++) add_tick(0, 16'h7FFF, 16'h7FFF);
		add_tick(1, 16'hFFFF, 16'hFFFF);
		wait_drained();
		cfg_write(CFG_STEP_TIME, 32'd0);
		cfg_write(CFG_INIT_X, 32'h7FFFFFFF);
		cfg_write(CFG_INIT_Y, 32'h80000000);
		cfg_write(CFG_INIT_HEADING, 32'd65535);
		cfg_write(CFG_INIT_VARIANCE, 32'h7FFFFFFF);
		cfg_write(CFG_UNLISTED_LO, 32'hFFFFFFFF);
		cfg_write(CFG_UNLISTED_HI, 32'h12345678);
		add_tick(1, 16'h0000, 16'h0000);
		add_tick(0, 16'h7FFF, 16'h7FFF);
		add_tick(0, 16'h8000, 16'h8000);
		wait_drained();
		cfg_write(CFG_STEP_TIME, 32'd65535);
		add_tick(1, 16'h0000, 16'h0000);
		add_tick(0, 16'h7FFF, 16'h7FFF);
		add_tick(0, 16'h7FFF, 16'h8000);
		add_tick(0, 16'h8000, 16'h1234);
		wait_drained();

		// random phases with changing settings
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: cfg_write(CFG_STEP_TIME, 32'(STEP_TIME_RST));
				1: cfg_write(CFG_STEP_TIME, 32'd1);
				2: cfg_write(CFG_STEP_TIME, 32'd65535);
				default: cfg_write(CFG_STEP_TIME, $urandom_range(65535));
			endcase
			cfg_write(CFG_INIT_X, (ph % 3 == 0) ? 32'h0 : $urandom);
			cfg_write(CFG_INIT_Y, (ph % 4 == 1) ? 32'h7FFFFFFF : $urandom);
			cfg_write(CFG_INIT_HEADING, (ph == 2) ? 32'd0 : $urandom_range(65535));
			cfg_write(CFG_INIT_VARIANCE, (ph == 3) ? 32'd0 :
				(ph % 2) ? 32'd1677722 : $urandom);
			idle_pct = (ph == 4) ? 0 : 21;
			add_tick(1, 16'($urandom), 16'($urandom));
			add_random(124);
			if (ph == 1) begin
				hold_seq++;
			end
			if (ph == 6) begin
				// sender waits until everything in flight is out
				while (pending_ticks.size() > 60) @(posedge clk);
				tx_pause = 1;
				while (s_axis_tvalid || pose_cov_q.size() > 0) @(posedge clk);
				tx_pause = 0;
			end
			wait_drained();
		end

		if (err_cnt == 0)
			$display("tb_unicycle_ekf_predict_top passed");
		else
			$display("tb_unicycle_ekf_predict_top failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ekfp_pkg.sv
rtl/core/ekfp_cordic.sv
rtl/core/ekfp_mul.sv
rtl/core/unicycle_ekf_predict_top.sv
rtl/core/ekfp_checker.sv
verif/tb_unicycle_ekf_predict_top.sv
